FILE: src/uer_pkg.sv
package uer_pkg;

    localparam int COUNTER_BITS_DEF = 12;
    localparam int TRIG_W = 8;
    localparam int TIMEOUT_W = 12;
    localparam int DIST_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [TRIG_W-1:0] TRIG_TICKS_RST = 8'd1;
    localparam logic [TIMEOUT_W-1:0] ECHO_TIMEOUT_RST = 12'd3200;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 2'd1;

    // distance = count * 10 >> 6
    localparam int DIST_MUL = 10;
    localparam int DIST_SHIFT = 6;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_EDGE  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        PH_READY     = 3'd0,
        PH_WAIT_TRIG = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_ECHO = 3'd3,
        PH_ECHO_HIGH = 3'd4,
        PH_FINISHED  = 3'd5,
        PH_FAILURE   = 3'd6
    } phase_t;

    typedef struct packed {
        logic              start_refused;
        phase_t            fsm_state;
        logic              trigger_level;
        logic              done_res;
        logic [DIST_W-1:0] range_cm;
    } uer_result_t;

endpackage

FILE: src/uer_core.sv
module uer_core import uer_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic [1:0]            cmd,
    input  logic                  level,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output uer_result_t           result
);

    localparam int CMP_W = (COUNTER_BITS > TIMEOUT_W) ? COUNTER_BITS : TIMEOUT_W;
    localparam int PROD_W = COUNTER_BITS + 4;

    phase_t                  phase_reg, phase_next;
    logic [COUNTER_BITS-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [TRIG_W-1:0]       trig_reg;
    logic [TIMEOUT_W-1:0]    timeout_reg;
    logic                    refused;
    logic                    inc_ge_trig, inc_ge_timeout;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W+DIST_W-1:0] prod_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_READY;
            cnt_reg     <= '0;
            trig_reg    <= TRIG_TICKS_RST;
            timeout_reg <= ECHO_TIMEOUT_RST;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (cfg_we && cfg_index == CFG_TRIGGER_TICKS) begin
                trig_reg <= cfg_data[TRIG_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_ECHO_TIMEOUT) begin
                timeout_reg <= cfg_data[TIMEOUT_W-1:0];
            end
        end
    end

    assign cnt_inc        = cnt_reg + 1'b1;
    assign inc_ge_trig    = CMP_W'(cnt_inc) >= CMP_W'(trig_reg);
    assign inc_ge_timeout = CMP_W'(cnt_inc) >= CMP_W'(timeout_reg);

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        refused    = 1'b0;
        if (step_en) begin
            case (cmd_t'(cmd))
                CMD_START: begin
                    if (phase_reg == PH_READY || phase_reg == PH_FINISHED ||
                        phase_reg == PH_FAILURE) begin
                        phase_next = PH_WAIT_TRIG;
                    end else begin
                        refused = 1'b1;
                    end
                end
                CMD_TICK: begin
                    case (phase_reg)
                        PH_WAIT_TRIG: begin
                            cnt_next   = '0;
                            phase_next = PH_TRIG_HIGH;
                        end
                        PH_TRIG_HIGH: begin
                            if (inc_ge_trig) begin
                                cnt_next   = '0;
                                phase_next = PH_WAIT_ECHO;
                            end else begin
                                cnt_next = cnt_inc;
                            end
                        end
                        PH_WAIT_ECHO, PH_ECHO_HIGH: begin
                            cnt_next = cnt_inc;
                            if (inc_ge_timeout) begin
                                phase_next = PH_FAILURE;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_EDGE: begin
                    if (phase_reg == PH_WAIT_ECHO) begin
                        if (level) begin
                            cnt_next   = '0;
                            phase_next = PH_ECHO_HIGH;
                        end else begin
                            phase_next = PH_FAILURE;
                        end
                    end else if (phase_reg == PH_ECHO_HIGH) begin
                        phase_next = level ? PH_FAILURE : PH_FINISHED;
                    end
                end
                default: ;
            endcase
        end
    end

    // x10 as shift-and-add
    assign prod     = (PROD_W'(cnt_next) << 3) + (PROD_W'(cnt_next) << 1);
    assign prod_ext = (PROD_W+DIST_W)'(prod) >> DIST_SHIFT;

    always_comb begin
        result.start_refused = refused;
        result.fsm_state     = phase_next;
        result.trigger_level = (phase_next == PH_TRIG_HIGH);
        result.done_res      = (phase_next == PH_FINISHED) || (phase_next == PH_FAILURE);
        result.range_cm      = (phase_next == PH_FINISHED) ? prod_ext[DIST_W-1:0] : '0;
    end

endmodule

FILE: src/ultrasonic_echo_ranger.sv
// A request is accepted into the input register; once the output register is free,
// the state update and the result register take it, and the result is on m_*.
// Throughput: one request per cycle while m_ready does not stall the output register.
// Reset (aresetn low, synchronous): state ready, tick count zero,
// trigger_ticks 1, echo_timeout_ticks 3200, both channels empty.
module ultrasonic_echo_ranger import uer_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic                  s_echo_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_start_refused,
    output logic [2:0]            m_fsm_state,
    output logic                  m_trigger_level,
    output logic                  m_done_res,
    output logic [DIST_W-1:0]     m_range_cm,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic        in_level_reg;
    logic        out_valid_reg;
    uer_result_t out_res_reg;
    uer_result_t core_res;
    logic        out_free, advance;

    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg   <= s_command;
            in_level_reg <= s_echo_level;
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    uer_core #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .cmd       (in_cmd_reg),
        .level     (in_level_reg),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (core_res)
    );

    assign m_valid         = out_valid_reg;
    assign m_start_refused = out_res_reg.start_refused;
    assign m_fsm_state     = out_res_reg.fsm_state;
    assign m_trigger_level = out_res_reg.trigger_level;
    assign m_done_res      = out_res_reg.done_res;
    assign m_range_cm      = out_res_reg.range_cm;

endmodule

FILE: src/uer_checker.sv
module uer_checker import uer_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_start_refused,
    input logic [2:0]        m_fsm_state,
    input logic              m_trigger_level,
    input logic              m_done_res,
    input logic [DIST_W-1:0] m_range_cm
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fsm_state) && $stable(m_range_cm))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_done_res == (m_fsm_state == PH_FINISHED || m_fsm_state == PH_FAILURE))
        else $error("done flag disagrees with state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_range_cm != '0 || m_trigger_level) |->
            (m_fsm_state == PH_FINISHED) != m_trigger_level &&
            (m_fsm_state == PH_FINISHED || m_fsm_state == PH_TRIG_HIGH))
        else $error("distance or trigger shown in wrong state");

    // a refused start leaves the controller busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_start_refused |->
            (m_fsm_state == PH_WAIT_TRIG || m_fsm_state == PH_TRIG_HIGH ||
             m_fsm_state == PH_WAIT_ECHO || m_fsm_state == PH_ECHO_HIGH))
        else $error("start refused while idle");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import uer_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [1:0] command;
        logic       echo_level;
    } ranger_req_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_command = CMD_START;
    logic                  s_echo_level = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_start_refused;
    logic [2:0]            m_fsm_state;
    logic                  m_trigger_level;
    logic                  m_done_res;
    logic [DIST_W-1:0]     m_range_cm;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TRIGGER_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predicted controller state and register copies
    phase_t                      ph_now = PH_READY;
    logic [COUNTER_BITS_DEF-1:0] tick_now = '0;
    logic [TRIG_W-1:0]           trig_len = TRIG_TICKS_RST;
    logic [TIMEOUT_W-1:0]        echo_limit = ECHO_TIMEOUT_RST;

    ranger_req_t pending_reqs[$];
    uer_result_t expected_readings[$];
    logic        req_open = 1'b0;
    int          queued = 0;
    int          send_gap = 0;
    bit          send_calm = 1'b0;
    int          recv_stall = 0;
    bit          recv_calm = 1'b0;
    int          readings_seen = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    ultrasonic_echo_ranger uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_echo_level    (s_echo_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_start_refused (m_start_refused),
        .m_fsm_state     (m_fsm_state),
        .m_trigger_level (m_trigger_level),
        .m_done_res      (m_done_res),
        .m_range_cm      (m_range_cm),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Advances the predicted controller by one request, returns the reading it gives.
    function automatic uer_result_t next_reading(logic [1:0] cmd, logic lvl);
        uer_result_t r;
        logic [31:0] scaled;
        r = '0;
        case (cmd)
            CMD_START: begin
                if (ph_now == PH_READY || ph_now == PH_FINISHED || ph_now == PH_FAILURE)
                    ph_now = PH_WAIT_TRIG;
                else
                    r.start_refused = 1'b1;
            end
            CMD_TICK: begin
                case (ph_now)
                    PH_WAIT_TRIG: begin
                        tick_now = '0;
                        ph_now = PH_TRIG_HIGH;
                    end
                    PH_TRIG_HIGH: begin
                        tick_now = tick_now + 1'b1;
                        if (tick_now >= trig_len) begin
                            ph_now = PH_WAIT_ECHO;
                            tick_now = '0;
                        end
                    end
                    PH_WAIT_ECHO, PH_ECHO_HIGH: begin
                        tick_now = tick_now + 1'b1;
                        if (tick_now >= echo_limit)
                            ph_now = PH_FAILURE;
                    end
                    default: ;
                endcase
            end
            CMD_EDGE: begin
                if (ph_now == PH_WAIT_ECHO) begin
                    if (lvl) begin
                        tick_now = '0;
                        ph_now = PH_ECHO_HIGH;
                    end else begin
                        ph_now = PH_FAILURE;
                    end
                end else if (ph_now == PH_ECHO_HIGH) begin
                    ph_now = lvl ? PH_FAILURE : PH_FINISHED;
                end
            end
            default: ;
        endcase
        if (ph_now == PH_FINISHED) begin
            scaled = 32'(tick_now) * DIST_MUL;
            r.range_cm = DIST_W'(scaled >> DIST_SHIFT);
        end
        r.fsm_state = ph_now;
        r.trigger_level = (ph_now == PH_TRIG_HIGH);
        r.done_res = (ph_now == PH_FINISHED || ph_now == PH_FAILURE);
        return r;
    endfunction

    function automatic int idle_len(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Tick count for a wait or echo stretch; past safe_max the measurement times out.
    function automatic int pick_ticks(int safe_max);
        int lim;
        int r;
        lim = (safe_max > 300) ? 300 : ((safe_max < 0) ? 0 : safe_max);
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, (lim < 12) ? lim : 12);
        if (r < 9 || safe_max > 300)
            return $urandom_range(0, lim);
        return safe_max + 1 + $urandom_range(0, 1);
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic add_req(logic [1:0] c, logic l);
        pending_reqs.push_back('{command: c, echo_level: l});
        queued++;
    endtask

    task automatic sprinkle(int odds);
        if ($urandom_range(1, odds) == 1)
            add_req(2'($urandom_range(0, 3)), rnd_bit());
    endtask

    task automatic add_ticks(int n);
        repeat (n) begin
            add_req(CMD_TICK, rnd_bit());
            sprinkle(40);
        end
    endtask

    // One measurement, mostly well formed: start, trigger, echo wait, echo, trailing events.
    task automatic add_measurement();
        int trig_need;
        int n;
        trig_need = 1 + ((trig_len == 0) ? 1 : int'(trig_len));
        add_req(CMD_START, rnd_bit());
        sprinkle(8);
        if ($urandom_range(0, 11) == 0)
            trig_need = $urandom_range(0, trig_need);
        add_ticks(trig_need);
        add_ticks(pick_ticks(int'(echo_limit) - 1));
        add_req(CMD_EDGE, $urandom_range(0, 7) != 0);
        sprinkle(8);
        add_ticks(pick_ticks(int'(echo_limit) - 1));
        add_req(CMD_EDGE, $urandom_range(0, 7) == 0);
        sprinkle(8);
        n = $urandom_range(0, 3);
        repeat (n) add_req(2'($urandom_range(1, 3)), rnd_bit());
    endtask

    // Returns once every request is sent and every reading is back.
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || req_open || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(int budget);
        queued = 0;
        while (queued < budget)
            add_measurement();
        wait_idle();
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TRIGGER_TICKS)
            trig_len = val[TRIG_W-1:0];
        else if (idx == CFG_ECHO_TIMEOUT)
            echo_limit = val[TIMEOUT_W-1:0];
        @(posedge aclk);
    endtask

    // request driver
    always @(posedge aclk) begin
        ranger_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
            req_open = 1'b0;
            ph_now = PH_READY;
            tick_now = '0;
        end else begin
            if (s_valid && s_ready) begin
                expected_readings.push_back(next_reading(s_command, s_echo_level));
                req_open = 1'b0;
            end
            if (s_valid && !s_ready) begin
                // hold the request until taken
            end else if (send_gap != 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                req_open = 1'b1;
                s_valid <= 1'b1;
                s_command <= nxt.command;
                s_echo_level <= nxt.echo_level;
                send_gap <= idle_len(send_calm);
                if ($urandom_range(0, 63) == 0)
                    send_calm <= !send_calm;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // reading monitor
    always @(posedge aclk) begin
        uer_result_t want;
        int n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("reading %0d with nothing expected",
                                              readings_seen));
                end else begin
                    want = expected_readings.pop_front();
                    if (m_start_refused !== want.start_refused)
                        report_mismatch($sformatf("reading %0d start_refused %b want %b",
                                        readings_seen, m_start_refused, want.start_refused));
                    if (m_fsm_state !== 3'(want.fsm_state))
                        report_mismatch($sformatf("reading %0d fsm_state %0d want %0d",
                                        readings_seen, m_fsm_state, want.fsm_state));
                    if (m_trigger_level !== want.trigger_level)
                        report_mismatch($sformatf("reading %0d trigger_level %b want %b",
                                        readings_seen, m_trigger_level, want.trigger_level));
                    if (m_done_res !== want.done_res)
                        report_mismatch($sformatf("reading %0d done_res %b want %b",
                                        readings_seen, m_done_res, want.done_res));
                    if (m_range_cm !== want.range_cm)
                        report_mismatch($sformatf("reading %0d range_cm %0d want %0d",
                                        readings_seen, m_range_cm, want.range_cm));
                end
                readings_seen++;
            end
            if (recv_stall != 0) begin
                m_ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else if (m_valid && m_ready) begin
                n = idle_len(recv_calm);
                m_ready <= (n == 0);
                recv_stall <= (n == 0) ? 0 : n - 1;
                if ($urandom_range(0, 63) == 0)
                    recv_calm <= !recv_calm;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("** ultrasonic_echo_ranger: FAILED **");
        $finish;
    end

    initial begin
        int k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk at reset settings (trigger 1 tick, timeout 3200)
        add_req(CMD_TICK, 1'b0);     // ignored while ready
        add_req(CMD_EDGE, 1'b1);     // ignored while ready
        add_req(CMD_UNUSED, 1'b1);
        add_req(CMD_START, 1'b0);
        add_req(CMD_START, 1'b1);    // refused
        add_req(CMD_EDGE, 1'b0);     // ignored while waiting for trigger
        add_req(CMD_TICK, 1'b1);
        add_req(CMD_UNUSED, 1'b0);
        add_req(CMD_TICK, 1'b0);
        add_req(CMD_START, 1'b0);    // refused while waiting for echo
        add_req(CMD_EDGE, 1'b0);     // low level while waiting -> failure
        add_req(CMD_TICK, 1'b0);
        add_req(CMD_START, 1'b1);    // restart from failure
        add_req(CMD_TICK, 1'b0);
        add_req(CMD_TICK, 1'b1);
        add_req(CMD_EDGE, 1'b1);
        add_req(CMD_START, 1'b0);    // refused during echo
        add_req(CMD_TICK, 1'b0);
        add_req(CMD_EDGE, 1'b1);     // high level during echo -> failure
        add_req(CMD_START, 1'b0);
        add_req(CMD_TICK, 1'b0);
        add_req(CMD_TICK, 1'b0);
        add_req(CMD_EDGE, 1'b1);
        add_req(CMD_TICK, 1'b1);
        add_req(CMD_EDGE, 1'b0);     // finished
        add_req(CMD_START, 1'b1);    // restart from finished
        wait_idle();

        // zero registers: one-tick trigger, fail on first counted tick
        write_reg(CFG_TRIGGER_TICKS, '0);
        write_reg(CFG_ECHO_TIMEOUT, '0);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        run_random(60);

        // longest trigger, upper data bits set to check they are dropped
        write_reg(CFG_TRIGGER_TICKS, CFG_DATA_W'($urandom_range(1, 15) << TRIG_W) | 12'hFF);
        write_reg(CFG_ECHO_TIMEOUT, 12'd1);
        run_random(200);

        // longest timeout with a long echo
        write_reg(CFG_TRIGGER_TICKS, 12'd1);
        write_reg(CFG_ECHO_TIMEOUT, 12'hFFF);
        add_req(CMD_START, 1'b0);
        add_req(CMD_TICK, 1'b0);
        add_req(CMD_TICK, 1'b0);
        add_req(CMD_EDGE, 1'b1);
        repeat (60) add_req(CMD_TICK, rnd_bit());
        add_req(CMD_EDGE, 1'b0);
        add_req(CMD_TICK, 1'b1);
        wait_idle();
        run_random(30);

        for (k = 0; k < 5; k++) begin
            write_reg(CFG_TRIGGER_TICKS, CFG_DATA_W'($urandom_range(1, 8)));
            if (k == 4)
                write_reg(CFG_ECHO_TIMEOUT, CFG_DATA_W'($urandom_range(100, 300)));
            else
                write_reg(CFG_ECHO_TIMEOUT, CFG_DATA_W'($urandom_range(2, 40)));
            run_random(40);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("** ultrasonic_echo_ranger: PASSED **");
        else
            $display("** ultrasonic_echo_ranger: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
src/uer_pkg.sv
src/uer_core.sv
src/ultrasonic_echo_ranger.sv
src/uer_checker.sv
dv/tb.sv
